[rtl/assert_macros.svh]
// Assertion macros shared by the RTL files of the console line editor.
// No dependencies; included by the files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Clocked assertion with a synchronous active-low reset that disables it.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);
// Implication form that checks the consequent in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);
`else
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

[rtl/cle_pkg.sv]
// Shared types and constants of the console line editor.
// No dependencies; used by every module of the block.
package cle_pkg;

    localparam int LINE_CAPACITY = 32;
    localparam int IDX_W         = $clog2(LINE_CAPACITY);
    localparam int CNT_W         = 6;
    localparam int CMD_DEPTH     = 2;

    localparam logic [7:0] BYTE_CR    = 8'h0D;
    localparam logic [7:0] BYTE_LF    = 8'h0A;
    localparam logic [7:0] BYTE_BS    = 8'h08;
    localparam logic [7:0] BYTE_DEL   = 8'h7F;
    localparam logic [7:0] BYTE_SPACE = 8'h20;

    localparam logic [1:0] KIND_ECHO = 2'd0;
    localparam logic [1:0] KIND_CHAR = 2'd1;
    localparam logic [1:0] KIND_END  = 2'd2;

    typedef enum logic [1:0] {
        OP_STORE = 2'd0,
        OP_ERASE = 2'd1,
        OP_LINE  = 2'd2
    } t_op;

    // One command for the back end: store, erase, or complete the line.
    typedef struct packed {
        t_op              op;
        logic [6:0]       ch;
        logic [CNT_W-1:0] len;
    } t_cmd;

    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_push;

endpackage

[rtl/cle_front.sv]
// Front end: accepts received bytes, tracks line length and CR state,
// and issues commands to the queue. Depends on cle_pkg.
module cle_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    input  logic [7:0]    s_axis_tdata,   // [7:0] rx_byte
    input  logic          i_full,
    output cle_pkg::t_push o_push
);
    import cle_pkg::*;

    logic [CNT_W-1:0] r_count, n_count;
    logic             r_saw_cr, n_saw_cr;
    logic             accept;
    logic [7:0]       c;

    assign s_axis_tready = !i_full;
    assign accept        = s_axis_tvalid && !i_full;
    assign c             = s_axis_tdata;

    always_comb begin
        n_count         = r_count;
        n_saw_cr        = r_saw_cr;
        o_push.valid    = 1'b0;
        o_push.cmd.op   = OP_STORE;
        o_push.cmd.ch   = c[6:0];
        o_push.cmd.len  = r_count;
        if (accept) begin
            if (c == BYTE_LF && r_saw_cr) begin
                n_saw_cr = 1'b0;
            end else begin
                n_saw_cr = (c == BYTE_CR);
                if (c == BYTE_CR || c == BYTE_LF) begin
                    o_push.valid  = 1'b1;
                    o_push.cmd.op = OP_LINE;
                    n_count       = '0;
                end else if (c == BYTE_BS || c == BYTE_DEL) begin
                    if (r_count != '0) begin
                        o_push.valid  = 1'b1;
                        o_push.cmd.op = OP_ERASE;
                        n_count       = r_count - 1'b1;
                    end
                end else if (c >= BYTE_SPACE && c < BYTE_DEL
                             && r_count < CNT_W'(LINE_CAPACITY - 1)) begin
                    // The new character goes to the slot at the current count.
                    o_push.valid = 1'b1;
                    n_count      = r_count + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_saw_cr <= 1'b0;
        end else begin
            r_count  <= n_count;
            r_saw_cr <= n_saw_cr;
        end
    end

endmodule

[rtl/cle_cmd_fifo.sv]
// Short command queue between the front end and the back end.
// Depends on cle_pkg for the command type and depth.
module cle_cmd_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  cle_pkg::t_push i_push,
    output logic           o_full,
    output logic           o_valid,
    output cle_pkg::t_cmd  o_cmd,
    input  logic           i_pop
);
    import cle_pkg::*;

    localparam int PTR_W = (CMD_DEPTH > 1) ? $clog2(CMD_DEPTH) : 1;
    localparam int FILL_W = $clog2(CMD_DEPTH + 1);

    t_cmd              r_slot [CMD_DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr, r_rd_ptr;
    logic [FILL_W-1:0] r_fill;
    logic              do_push, do_pop;

    assign o_full  = (r_fill == FILL_W'(CMD_DEPTH));
    assign o_valid = (r_fill != '0);
    assign o_cmd   = r_slot[r_rd_ptr];
    assign do_push = i_push.valid && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wr_ptr] <= i_push.cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(CMD_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(CMD_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_fill <= r_fill + 1'b1;
                2'b01:   r_fill <= r_fill - 1'b1;
                default: r_fill <= r_fill;
            endcase
        end
    end

endmodule

[rtl/cle_back.sv]
// Back end: executes queued commands, owns the line store, and drives
// the registered output word. Depends on cle_pkg.
module cle_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  cle_pkg::t_cmd i_cmd,
    output logic          o_pop,
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    output logic [15:0]   m_axis_tdata,   // [7:0] out_byte, [13:8] line_length, zero pad
    output logic [1:0]    m_axis_tuser,   // [1:0] out_kind
    output logic          m_axis_tlast    // last
);
    import cle_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_ERASE_SP,
        S_ERASE_BS,
        S_LINE
    } t_state;

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_idx, n_idx;
    logic [CNT_W-1:0] r_len, n_len;
    logic [6:0]       r_store [LINE_CAPACITY];
    logic [6:0]       r_rd_data;
    logic             mem_we;

    logic             r_out_valid;
    logic [1:0]       r_out_kind;
    logic [7:0]       r_out_byte;
    logic [CNT_W-1:0] r_out_len;
    logic             r_out_last;

    logic             out_free, emit, e_last;
    logic [1:0]       e_kind;
    logic [7:0]       e_byte;
    logic [CNT_W-1:0] e_len;

    assign out_free = !r_out_valid || m_axis_tready;

    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        n_len   = r_len;
        o_pop   = 1'b0;
        mem_we  = 1'b0;
        emit    = 1'b0;
        e_kind  = KIND_ECHO;
        e_byte  = '0;
        e_len   = '0;
        e_last  = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid && out_free) begin
                    o_pop = 1'b1;
                    emit  = 1'b1;
                    unique case (i_cmd.op)
                        OP_STORE: begin
                            mem_we = 1'b1;
                            e_byte = {1'b0, i_cmd.ch};
                            e_last = 1'b1;
                        end
                        OP_ERASE: begin
                            e_byte  = BYTE_BS;
                            n_state = S_ERASE_SP;
                        end
                        OP_LINE: begin
                            e_byte  = BYTE_LF;
                            n_idx   = '0;
                            n_len   = i_cmd.len;
                            n_state = S_LINE;
                        end
                        default: begin
                            emit = 1'b0;
                        end
                    endcase
                end
            end
            S_ERASE_SP: begin
                if (out_free) begin
                    emit    = 1'b1;
                    e_byte  = BYTE_SPACE;
                    n_state = S_ERASE_BS;
                end
            end
            S_ERASE_BS: begin
                if (out_free) begin
                    emit    = 1'b1;
                    e_byte  = BYTE_BS;
                    e_last  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_LINE: begin
                if (out_free) begin
                    emit = 1'b1;
                    if (r_idx == r_len) begin
                        e_kind  = KIND_END;
                        e_len   = r_len;
                        e_last  = 1'b1;
                        n_state = S_IDLE;
                    end else begin
                        e_kind = KIND_CHAR;
                        e_byte = {1'b0, r_rd_data};
                        n_idx  = r_idx + 1'b1;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // The read address follows the next index, so the registered data
    // always belongs to the current index.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_store[i_cmd.len[IDX_W-1:0]] <= i_cmd.ch;
        end
        r_rd_data <= r_store[n_idx[IDX_W-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
        r_idx <= n_idx;
        r_len <= n_len;
        if (emit) begin
            r_out_kind <= e_kind;
            r_out_byte <= e_byte;
            r_out_len  <= e_len;
            r_out_last <= e_last;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {2'b00, r_out_len, r_out_byte};
    assign m_axis_tuser  = r_out_kind;
    assign m_axis_tlast  = r_out_last;

endmodule

[rtl/console_line_editor.sv]
// Top level of the console line editor: front end, command queue, back end.
// Depends on cle_pkg, cle_front, cle_cmd_fifo, cle_back and assert_macros.svh.
//
//  Channel   Direction  tdata               tuser       tlast
//  s_axis    in         rx_byte [7:0]       -           -
//  m_axis    out        out_byte [7:0],     out_kind    last
//                       line_length [13:8]
//
// The front end takes one byte a cycle while the command queue has room. The back
// end issues one output word a cycle while the output register is free: an echo
// gives one word, an erase three and a line end with N characters N+2. Synchronous
// active-low reset empties the queue and the output register and clears the length
// and CR state. A stalled output holds its word; the front keeps accepting until
// the queue fills.
`include "assert_macros.svh"

module console_line_editor (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [7:0] out_byte, [13:8] line_length, [15:14] zero
    output logic [1:0]  m_axis_tuser,   // [1:0] out_kind
    output logic        m_axis_tlast    // last
);
    import cle_pkg::*;

    t_push      push;
    t_cmd       cmd;
    logic       fifo_full, fifo_valid, pop;
    logic       out_end, out_mid;
    logic [5:0] out_len;

    // Classification, line length and CR/LF pairing happen here.
    cle_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .i_full        (fifo_full),
        .o_push        (push)
    );

    // Commands wait here so that the byte stream keeps flowing while a
    // line is replayed.
    cle_cmd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_full  (fifo_full),
        .o_valid (fifo_valid),
        .o_cmd   (cmd),
        .i_pop   (pop)
    );

    // Stores characters, replays the line and sequences the echo words.
    cle_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (fifo_valid),
        .i_cmd         (cmd),
        .o_pop         (pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // Output word classes seen by the checks below.
    assign out_end = m_axis_tvalid && (m_axis_tuser == KIND_END);
    assign out_mid = m_axis_tvalid && (m_axis_tuser != KIND_END);
    assign out_len = m_axis_tdata[13:8];

    // The front end must never issue a command that the queue cannot hold.
    `ASSERT_CLK(a_no_push_full, i_clk, i_rst_n, !(push.valid && fifo_full), "push on full queue")
    // An end-of-line word always closes the results of its byte.
    `ASSERT_CLK(a_end_is_last, i_clk, i_rst_n, !out_end || m_axis_tlast, "end of line without last")
    // Only the end-of-line word carries a length.
    `ASSERT_CLK(a_len_at_end, i_clk, i_rst_n, !out_mid || out_len == '0, "stray line length")
    // A popped command always produces an output word in the next cycle.
    `ASSERT_NEXT(a_pop_emits, i_clk, i_rst_n, pop, m_axis_tvalid, "popped command gave no word")

endmodule
